// ----- hw/rtl/spol_pkg.sv -----
// Shared constants, codes and types of the stable priority list.
package spol_pkg;

  localparam int unsigned KEY_W          = 32;
  localparam int unsigned MODE_W         = 3;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned ACTOR_BITS_DEF = 16;

  typedef enum logic [MODE_W-1:0] {
    OP_INSERT = 3'd0,
    OP_ERASE  = 3'd1,
    OP_FIRST  = 3'd2,
    OP_NEXT   = 3'd3,
    OP_VALUE  = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

  typedef struct packed {
    logic insert;
    logic erase;
    logic ahead;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/spol_if.sv -----
// Valid/ready channel interfaces for the command and response beats.
interface spol_in_if #(
  parameter int unsigned HANDLE_W = 7,
  parameter int unsigned ACTOR_W  = 16
);
  import spol_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic signed [KEY_W-1:0]    key;
  logic [ACTOR_W-1:0]         actor_id;
  logic                       place_before_equal;
  logic [HANDLE_W-1:0]        handle_in;

  modport source (output valid, mode, key, actor_id, place_before_equal, handle_in,
                  input ready);
  modport sink   (input valid, mode, key, actor_id, place_before_equal, handle_in,
                  output ready);
endinterface

interface spol_out_if #(
  parameter int unsigned HANDLE_W = 7,
  parameter int unsigned ACTOR_W  = 16
);
  import spol_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [HANDLE_W-1:0]  handle_out;
  logic [ACTOR_W-1:0]   actor_out;
  logic [STATUS_W-1:0]  status;
  logic [HANDLE_W-1:0]  entry_count;

  modport source (output valid, handle_out, actor_out, status, entry_count, input ready);
  modport sink   (input valid, handle_out, actor_out, status, entry_count, output ready);
endinterface

// ----- hw/rtl/spol_cell.sv -----
// One sorted-list cell: holds an entry, compares it, shifts with its neighbors.
module spol_cell #(
  parameter int unsigned ACTOR_W = 16,
  parameter int unsigned TAG_W   = 6,
  parameter int unsigned IDX     = 0
) (
  input  logic                           clk_i,
  input  spol_pkg::cell_ctrl_t           ctrl_i,
  input  logic                           valid_i,
  input  logic signed [spol_pkg::KEY_W-1:0] new_key_i,
  input  logic [ACTOR_W-1:0]             new_actor_i,
  input  logic [TAG_W-1:0]               new_tag_i,
  input  logic [TAG_W-1:0]               hin_tag_i,
  input  logic [TAG_W-1:0]               erase_pos_i,
  input  logic                           left_ins_i,
  input  logic signed [spol_pkg::KEY_W-1:0] left_key_i,
  input  logic [ACTOR_W-1:0]             left_actor_i,
  input  logic [TAG_W-1:0]               left_tag_i,
  input  logic signed [spol_pkg::KEY_W-1:0] right_key_i,
  input  logic [ACTOR_W-1:0]             right_actor_i,
  input  logic [TAG_W-1:0]               right_tag_i,
  output logic signed [spol_pkg::KEY_W-1:0] key_o,
  output logic [ACTOR_W-1:0]             actor_o,
  output logic [TAG_W-1:0]               tag_o,
  output logic                           ins_o,
  output logic                           match_o
);
  import spol_pkg::*;

  localparam logic [TAG_W-1:0] MY_POS = TAG_W'(IDX);

  logic signed [KEY_W-1:0] key_q, key_d;
  logic [ACTOR_W-1:0]      actor_q, actor_d;
  logic [TAG_W-1:0]        tag_q, tag_d;

  // new entry lands at or left of this cell
  assign ins_o   = !valid_i || (ctrl_i.ahead ? (key_q >= new_key_i) : (key_q > new_key_i));
  assign match_o = valid_i && (tag_q == hin_tag_i);

  always_comb begin
    key_d   = key_q;
    actor_d = actor_q;
    tag_d   = tag_q;
    if (ctrl_i.insert && ins_o) begin
      if (left_ins_i) begin
        key_d   = left_key_i;
        actor_d = left_actor_i;
        tag_d   = left_tag_i;
      end else begin
        key_d   = new_key_i;
        actor_d = new_actor_i;
        tag_d   = new_tag_i;
      end
    end else if (ctrl_i.erase && (MY_POS >= erase_pos_i)) begin
      key_d   = right_key_i;
      actor_d = right_actor_i;
      tag_d   = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    actor_q <= actor_d;
    tag_q   <= tag_d;
  end

  assign key_o   = key_q;
  assign actor_o = actor_q;
  assign tag_o   = tag_q;

endmodule

// ----- hw/rtl/spol_tag_alloc.sv -----
// Handle tag allocator: in-use bits and lowest-free-tag search.
module spol_tag_alloc #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned TAG_W    = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                set_i,
  input  logic [TAG_W-1:0]    set_tag_i,
  input  logic                clr_i,
  input  logic [TAG_W-1:0]    clr_tag_i,
  input  logic                clear_all_i,
  output logic [TAG_W-1:0]    free_tag_o,
  output logic [CAPACITY-1:0] in_use_o
);
  logic [CAPACITY-1:0] in_use_q, in_use_d;

  always_comb begin
    in_use_d = in_use_q;
    for (int i = 0; i < CAPACITY; i++) begin
      if (set_i && (set_tag_i == TAG_W'(i))) in_use_d[i] = 1'b1;
      if (clr_i && (clr_tag_i == TAG_W'(i))) in_use_d[i] = 1'b0;
    end
    if (clear_all_i) in_use_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else begin
      in_use_q <= in_use_d;
    end
  end

  always_comb begin
    free_tag_o = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!in_use_q[i]) free_tag_o = TAG_W'(i);
    end
  end

  assign in_use_o = in_use_q;

endmodule

// ----- hw/rtl/stable_priority_ordered_list.sv -----
// Top level of the stable priority list: control, cell row and result register.
//
// Usage: one command beat on in_i (insert, erase, first, next, value, clear)
// gives exactly one response beat on out_o. Entries sit in a row of CAPACITY
// cells kept in ascending signed key order; an insert shifts the cells right of
// the insertion point by one, an erase shifts them left.
// A taken beat is registered and moves the control to the lookup state; the lookup
// registers the response. Each command passes accept (idle), then a parallel compare
// over all cells (lookup); an erase that hits adds a left-shift state. No new command
// is taken until the control is back in idle.
// in_i.ready is high only when the control is idle and the response register
// is empty or being drained in the same cycle; a stalled out_o holds the
// response and blocks further commands.
// Reset clears the occupancy, the tag in-use bits and both handshakes; cell
// contents are not reset and are read only below the occupancy.
module stable_priority_ordered_list #(
  parameter int unsigned CAPACITY   = spol_pkg::CAPACITY_DEF,
  parameter int unsigned ACTOR_BITS = spol_pkg::ACTOR_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spol_in_if.sink    in_i,
  spol_out_if.source out_o
);
  import spol_pkg::*;

  localparam int unsigned TAG_W    = $clog2(CAPACITY);
  localparam int unsigned HANDLE_W = $clog2(CAPACITY + 1);
  localparam logic [HANDLE_W-1:0] END_MARK = HANDLE_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_LOOK  = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [MODE_W-1:0]       mode_q;
  logic signed [KEY_W-1:0] key_q;
  logic [ACTOR_BITS-1:0]   actor_q;
  logic                    before_q;
  logic [HANDLE_W-1:0]     hin_q;
  logic [HANDLE_W-1:0]     occ_q, occ_d;
  logic [TAG_W-1:0]        pos_q;

  logic                    out_valid_q, out_valid_d;
  logic [HANDLE_W-1:0]     res_handle_q, res_handle;
  logic [ACTOR_BITS-1:0]   res_actor_q, res_actor;
  status_e                 res_status_q, res_status;

  logic in_fire;
  logic look;
  logic full;
  logic found;
  logic go_shift;

  logic                set_tag, clr_tag, clear_all;
  logic [TAG_W-1:0]    free_tag;
  logic [CAPACITY-1:0] in_use;

  cell_ctrl_t cell_ctrl;

  logic signed [KEY_W-1:0] c_key [CAPACITY];
  logic [ACTOR_BITS-1:0]   c_actor [CAPACITY];
  logic [TAG_W-1:0]        c_tag [CAPACITY];
  logic [CAPACITY-1:0]     c_ins, c_match, c_valid;

  logic                    lft_ins [CAPACITY];
  logic signed [KEY_W-1:0] lft_key [CAPACITY];
  logic [ACTOR_BITS-1:0]   lft_actor [CAPACITY];
  logic [TAG_W-1:0]        lft_tag [CAPACITY];
  logic signed [KEY_W-1:0] rgt_key [CAPACITY];
  logic [ACTOR_BITS-1:0]   rgt_actor [CAPACITY];
  logic [TAG_W-1:0]        rgt_tag [CAPACITY];

  logic                  nxt_hit;
  logic [TAG_W-1:0]      nxt_tag;
  logic [ACTOR_BITS-1:0] val_actor;
  logic [TAG_W-1:0]      hit_pos;
  logic [HANDLE_W-1:0]   nxt_handle, first_handle;

  assign in_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;
  assign look       = (state_q == S_LOOK);
  assign full       = (occ_q == END_MARK);

  // cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign c_valid[g] = (occ_q > HANDLE_W'(g));

    if (g == 0) begin : g_head
      assign lft_ins[g]   = 1'b0;
      assign lft_key[g]   = key_q;
      assign lft_actor[g] = actor_q;
      assign lft_tag[g]   = free_tag;
    end else begin : g_mid
      assign lft_ins[g]   = c_ins[g-1];
      assign lft_key[g]   = c_key[g-1];
      assign lft_actor[g] = c_actor[g-1];
      assign lft_tag[g]   = c_tag[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign rgt_key[g]   = c_key[g];
      assign rgt_actor[g] = c_actor[g];
      assign rgt_tag[g]   = c_tag[g];
    end else begin : g_body
      assign rgt_key[g]   = c_key[g+1];
      assign rgt_actor[g] = c_actor[g+1];
      assign rgt_tag[g]   = c_tag[g+1];
    end

    spol_cell #(
      .ACTOR_W (ACTOR_BITS),
      .TAG_W   (TAG_W),
      .IDX     (g)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl),
      .valid_i       (c_valid[g]),
      .new_key_i     (key_q),
      .new_actor_i   (actor_q),
      .new_tag_i     (free_tag),
      .hin_tag_i     (hin_q[TAG_W-1:0]),
      .erase_pos_i   (pos_q),
      .left_ins_i    (lft_ins[g]),
      .left_key_i    (lft_key[g]),
      .left_actor_i  (lft_actor[g]),
      .left_tag_i    (lft_tag[g]),
      .right_key_i   (rgt_key[g]),
      .right_actor_i (rgt_actor[g]),
      .right_tag_i   (rgt_tag[g]),
      .key_o         (c_key[g]),
      .actor_o       (c_actor[g]),
      .tag_o         (c_tag[g]),
      .ins_o         (c_ins[g]),
      .match_o       (c_match[g])
    );
  end

  spol_tag_alloc #(
    .CAPACITY (CAPACITY),
    .TAG_W    (TAG_W)
  ) u_tag_alloc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .set_i       (set_tag),
    .set_tag_i   (free_tag),
    .clr_i       (clr_tag),
    .clr_tag_i   (hin_q[TAG_W-1:0]),
    .clear_all_i (clear_all),
    .free_tag_o  (free_tag),
    .in_use_o    (in_use)
  );

  // one-hot match reductions
  always_comb begin
    nxt_hit   = 1'b0;
    nxt_tag   = '0;
    val_actor = '0;
    hit_pos   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      val_actor = val_actor | ({ACTOR_BITS{c_match[i]}} & c_actor[i]);
      hit_pos   = hit_pos | ({TAG_W{c_match[i]}} & TAG_W'(i));
    end
    for (int i = 1; i < CAPACITY; i++) begin
      nxt_hit = nxt_hit | (c_match[i-1] & c_valid[i]);
      nxt_tag = nxt_tag | ({TAG_W{c_match[i-1] & c_valid[i]}} & c_tag[i]);
    end
  end

  assign found        = (hin_q < END_MARK) && (|c_match);
  assign nxt_handle   = nxt_hit ? HANDLE_W'(nxt_tag) : END_MARK;
  assign first_handle = c_valid[0] ? HANDLE_W'(c_tag[0]) : END_MARK;

  always_comb begin
    res_handle = END_MARK;
    res_actor  = '0;
    res_status = ST_OK;
    occ_d      = occ_q;
    set_tag    = 1'b0;
    clr_tag    = 1'b0;
    clear_all  = 1'b0;
    go_shift   = 1'b0;
    unique case (op_e'(mode_q))
      OP_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_handle = HANDLE_W'(free_tag);
          set_tag    = look;
          occ_d      = occ_q + HANDLE_W'(1);
        end
      end
      OP_ERASE: begin
        if (!found) begin
          res_status = ST_UNKNOWN;
        end else begin
          res_handle = nxt_handle;
          clr_tag    = look;
          occ_d      = occ_q - HANDLE_W'(1);
          go_shift   = 1'b1;
        end
      end
      OP_FIRST: begin
        res_handle = first_handle;
      end
      OP_NEXT: begin
        if (!found) begin
          res_status = ST_UNKNOWN;
        end else begin
          res_handle = nxt_handle;
        end
      end
      OP_VALUE: begin
        if (!found) begin
          res_status = ST_UNKNOWN;
        end else begin
          res_actor = val_actor;
        end
      end
      OP_CLEAR: begin
        clear_all = look;
        occ_d     = '0;
      end
      default: ;
    endcase
  end

  assign cell_ctrl.insert = look && (op_e'(mode_q) == OP_INSERT) && !full;
  assign cell_ctrl.erase  = (state_q == S_SHIFT);
  assign cell_ctrl.ahead  = before_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_LOOK;
      end
      S_LOOK: begin
        out_valid_d = 1'b1;
        state_d     = go_shift ? S_SHIFT : S_IDLE;
      end
      S_SHIFT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (look) occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q   <= in_i.mode;
      key_q    <= in_i.key;
      actor_q  <= in_i.actor_id;
      before_q <= in_i.place_before_equal;
      hin_q    <= in_i.handle_in;
    end
    if (look) begin
      pos_q        <= hit_pos;
      res_handle_q <= res_handle;
      res_actor_q  <= res_actor;
      res_status_q <= res_status;
    end
  end

  logic [HANDLE_W-1:0] count_q;

  always_ff @(posedge clk_i) begin
    if (look) count_q <= occ_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.handle_out  = res_handle_q;
  assign out_o.actor_out   = res_actor_q;
  assign out_o.status      = res_status_q;
  assign out_o.entry_count = count_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= END_MARK)
    else $error("occupancy above capacity");

  a_tags_match_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(in_use) == int'(occ_q))
    else $error("in-use tags disagree with occupancy");

  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_LOOK))
    else $error("accepted beat not looked up");

  a_look_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |=> out_valid_q)
    else $error("lookup gave no response beat");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the stable priority ordered list.
module testbench;
  import spol_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned HANDLE_W    = 7;
  localparam int unsigned ACTOR_W     = 16;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned HOLD_CYCLES = 300;

  localparam logic [HANDLE_W-1:0] END_HANDLE   = HANDLE_W'(CAPACITY);
  localparam logic [MODE_W-1:0]   MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0]   MODE_SPARE_7 = 3'd7;
  localparam logic signed [KEY_W-1:0] KEY_MIN  = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX  = 32'sh7fff_ffff;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [KEY_W-1:0] key;
    logic [ACTOR_W-1:0]      actor;
    logic                    ahead;
    logic [HANDLE_W-1:0]     handle;
  } cmd_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [ACTOR_W-1:0]  actor;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] count;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  spol_in_if  #(.HANDLE_W(HANDLE_W), .ACTOR_W(ACTOR_W)) cmd_if ();
  spol_out_if #(.HANDLE_W(HANDLE_W), .ACTOR_W(ACTOR_W)) rsp_if ();

  stable_priority_ordered_list #(
    .CAPACITY  (CAPACITY),
    .ACTOR_BITS(ACTOR_W)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (rsp_if)
  );

  // Mirror of the sorted list
  logic signed [KEY_W-1:0] key_at   [CAPACITY];
  logic [ACTOR_W-1:0]      actor_at [CAPACITY];
  logic [5:0]              tag_at   [CAPACITY];
  logic                    tag_busy [CAPACITY];
  int unsigned             live_count;

  reply_t      pending_replies[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_hold_req;
  int unsigned rx_hold_left;
  reply_t      want_reply;
  cmd_t        seen_cmd;

  always #5 clk_i = ~clk_i;

  function automatic int unsigned position_of(logic [HANDLE_W-1:0] h);
    int unsigned i;
    if (h >= CAPACITY) return live_count;
    if (!tag_busy[h[5:0]]) return live_count;
    for (i = 0; i < live_count; i++) begin
      if (tag_at[i] == h[5:0]) return i;
    end
    return live_count;
  endfunction

  function automatic reply_t apply_list_op(cmd_t c);
    reply_t      r;
    int unsigned pos;
    int unsigned tag;
    int unsigned i;
    r.handle = END_HANDLE;
    r.actor  = '0;
    r.status = ST_OK;
    case (c.mode)
      OP_INSERT: begin
        if (live_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          tag = 0;
          while (tag_busy[tag]) tag++;
          pos = 0;
          while (pos < live_count &&
                 !(c.ahead ? (key_at[pos] >= $signed(c.key)) : (key_at[pos] > $signed(c.key))))
            pos++;
          for (i = live_count; i > pos; i--) begin
            key_at[i]   = key_at[i-1];
            actor_at[i] = actor_at[i-1];
            tag_at[i]   = tag_at[i-1];
          end
          key_at[pos]   = c.key;
          actor_at[pos] = c.actor;
          tag_at[pos]   = tag[5:0];
          tag_busy[tag] = 1'b1;
          live_count++;
          r.handle = HANDLE_W'(tag);
        end
      end
      OP_ERASE: begin
        pos = position_of(c.handle);
        if (pos >= live_count) begin
          r.status = ST_UNKNOWN;
        end else begin
          tag_busy[tag_at[pos]] = 1'b0;
          for (i = pos; i + 1 < live_count; i++) begin
            key_at[i]   = key_at[i+1];
            actor_at[i] = actor_at[i+1];
            tag_at[i]   = tag_at[i+1];
          end
          live_count--;
          if (pos < live_count) r.handle = HANDLE_W'(tag_at[pos]);
        end
      end
      OP_FIRST: begin
        if (live_count > 0) r.handle = HANDLE_W'(tag_at[0]);
      end
      OP_NEXT: begin
        pos = position_of(c.handle);
        if (pos >= live_count) r.status = ST_UNKNOWN;
        else if (pos + 1 < live_count) r.handle = HANDLE_W'(tag_at[pos+1]);
      end
      OP_VALUE: begin
        pos = position_of(c.handle);
        if (pos >= live_count) r.status = ST_UNKNOWN;
        else r.actor = actor_at[pos];
      end
      OP_CLEAR: begin
        for (i = 0; i < CAPACITY; i++) tag_busy[i] = 1'b0;
        live_count = 0;
      end
      default: ;
    endcase
    r.count = HANDLE_W'(live_count);
    return r;
  endfunction

  function automatic cmd_t mk_cmd(logic [MODE_W-1:0] mode, logic signed [KEY_W-1:0] key,
                                  logic [ACTOR_W-1:0] actor, logic ahead,
                                  logic [HANDLE_W-1:0] handle);
    cmd_t c;
    c.mode   = mode;
    c.key    = key;
    c.actor  = actor;
    c.ahead  = ahead;
    c.handle = handle;
    return c;
  endfunction

  function automatic cmd_t random_cmd(int unsigned insert_pct);
    cmd_t        c;
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    case ($urandom_range(9))
      0:          c.key = KEY_MIN;
      1:          c.key = KEY_MAX;
      2, 3, 4, 5: c.key = int'($urandom_range(6)) - 3;
      default:    c.key = $urandom;
    endcase
    // a key of zero gets a null actor half of the time
    if (c.key == 0 && $urandom_range(1) == 0) c.actor = '0;
    else c.actor = ACTOR_W'($urandom_range(65535));
    c.ahead = 1'($urandom_range(1));
    if (live_count > 0 && $urandom_range(4) != 0)
      c.handle = HANDLE_W'(tag_at[$urandom_range(live_count - 1)]);
    else
      c.handle = HANDLE_W'($urandom_range(CAPACITY));
    if (pick < insert_pct) c.mode = OP_INSERT;
    else if (sel < 30) c.mode = OP_ERASE;
    else if (sel < 55) c.mode = OP_NEXT;
    else if (sel < 80) c.mode = OP_VALUE;
    else if (sel < 90) c.mode = OP_FIRST;
    else if (sel < 96) c.mode = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
    else c.mode = OP_CLEAR;
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Starts at any time, returns at the rising edge where the beat is taken.
  task automatic send_cmd(input cmd_t c);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid              <= 1'b1;
    cmd_if.mode               <= c.mode;
    cmd_if.key                <= c.key;
    cmd_if.actor_id           <= c.actor;
    cmd_if.place_before_equal <= c.ahead;
    cmd_if.handle_in          <= c.handle;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
  endtask

  task automatic wait_replies_done();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic test_directed_ops();
    send_cmd(mk_cmd(OP_FIRST,  '0, '0, 1'b0, '0));
    send_cmd(mk_cmd(OP_NEXT,   '0, '0, 1'b0, END_HANDLE));
    send_cmd(mk_cmd(OP_VALUE,  '0, '0, 1'b0, '0));
    send_cmd(mk_cmd(OP_ERASE,  '0, '0, 1'b0, 7'd5));
    send_cmd(mk_cmd(OP_INSERT, '0, 16'h0000, 1'b0, '0));
    send_cmd(mk_cmd(OP_INSERT, KEY_MIN, 16'hffff, 1'b1, '0));
    send_cmd(mk_cmd(OP_INSERT, KEY_MAX, 16'h1234, 1'b0, '0));
    send_cmd(mk_cmd(OP_INSERT, '0, 16'h5555, 1'b1, '0));
    send_cmd(mk_cmd(OP_INSERT, '0, 16'haaaa, 1'b0, '0));
    send_cmd(mk_cmd(OP_FIRST,  '0, '0, 1'b0, '0));
    send_cmd(mk_cmd(OP_NEXT,   '0, '0, 1'b0, 7'd1));
    send_cmd(mk_cmd(OP_NEXT,   '0, '0, 1'b0, 7'd3));
    send_cmd(mk_cmd(OP_NEXT,   '0, '0, 1'b0, 7'd2));
    send_cmd(mk_cmd(OP_VALUE,  '0, '0, 1'b0, 7'd4));
    send_cmd(mk_cmd(OP_VALUE,  '0, '0, 1'b0, END_HANDLE));
    send_cmd(mk_cmd(OP_ERASE,  '0, '0, 1'b0, 7'd0));
    send_cmd(mk_cmd(OP_ERASE,  '0, '0, 1'b0, 7'd2));
    send_cmd(mk_cmd(OP_INSERT, -32'sd1, 16'h0007, 1'b1, '0));
    send_cmd(mk_cmd(MODE_SPARE_6, -32'sd1, 16'hffff, 1'b1, 7'd63));
    send_cmd(mk_cmd(MODE_SPARE_7, KEY_MAX, 16'h8001, 1'b0, END_HANDLE));
    send_cmd(mk_cmd(OP_CLEAR,  '0, '0, 1'b0, '0));
    send_cmd(mk_cmd(OP_FIRST,  '0, '0, 1'b0, '0));
    send_cmd(mk_cmd(OP_VALUE,  '0, '0, 1'b0, 7'd1));
    send_cmd(mk_cmd(OP_INSERT, '0, 16'h0000, 1'b1, '0));
    wait_replies_done();
  endtask

  // Fill to capacity, hit rejects, then churn around the full mark.
  task automatic test_full_store();
    int unsigned n;
    send_cmd(mk_cmd(OP_CLEAR, '0, '0, 1'b0, '0));
    for (n = 0; n < 72; n++) send_cmd(random_cmd(100));
    for (n = 0; n < 30; n++) send_cmd(random_cmd(50));
    wait_replies_done();
  endtask

  // Receiver holds off while commands keep coming.
  task automatic test_stall_and_refill();
    int unsigned n;
    send_cmd(random_cmd(100));
    rx_hold_req = HOLD_CYCLES;
    for (n = 0; n < 40; n++) send_cmd(random_cmd(60));
    wait_replies_done();
  endtask

  task automatic test_random_mix(input int unsigned count, input int unsigned tx_pct,
                                 input int unsigned rx_pct);
    int unsigned n;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (n = 0; n < count; n++) send_cmd(random_cmd(40));
    wait_replies_done();
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      rx_hold_left--;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Reply check first, then record the command beat taken at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("reply beat with nothing outstanding");
        end else begin
          want_reply = pending_replies.pop_front();
          check_field("handle_out",  32'(rsp_if.handle_out),  32'(want_reply.handle));
          check_field("actor_out",   32'(rsp_if.actor_out),   32'(want_reply.actor));
          check_field("status",      32'(rsp_if.status),      32'(want_reply.status));
          check_field("entry_count", 32'(rsp_if.entry_count), 32'(want_reply.count));
        end
      end
      if (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) begin
        seen_cmd = mk_cmd(cmd_if.mode, cmd_if.key, cmd_if.actor_id,
                          cmd_if.place_before_equal, cmd_if.handle_in);
        pending_replies.push_back(apply_list_op(seen_cmd));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    clk_i                     = 1'b0;
    rst_ni                    = 1'b0;
    cmd_if.valid              = 1'b0;
    cmd_if.mode               = OP_INSERT;
    cmd_if.key                = '0;
    cmd_if.actor_id           = '0;
    cmd_if.place_before_equal = 1'b0;
    cmd_if.handle_in          = '0;
    rsp_if.ready              = 1'b0;
    mismatch_count            = 0;
    cycle_count               = 0;
    rx_hold_req               = 0;
    rx_hold_left              = 0;
    live_count                = 0;
    tx_idle_pct               = 13;
    rx_idle_pct               = 62;
    for (int i = 0; i < CAPACITY; i++) begin
      tag_busy[i] = 1'b0;
      key_at[i]   = '0;
      actor_at[i] = '0;
      tag_at[i]   = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_ops();
    test_full_store();
    test_stall_and_refill();
    test_random_mix(250, 13, 62);
    test_random_mix(250, 62, 13);
    test_random_mix(250, 0, 0);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/spol_pkg.sv
hw/rtl/spol_if.sv
hw/rtl/spol_cell.sv
hw/rtl/spol_tag_alloc.sv
hw/rtl/stable_priority_ordered_list.sv
tb/testbench.sv
